>>> hdl/pbx_call_state_controller_macros.svh
// ----------------------------------------------------------------------------
// pbx_call_state_controller_macros
// Assertion shorthands shared by the call state controller RTL.
// ----------------------------------------------------------------------------
`ifndef PBX_CALL_STATE_CONTROLLER_MACROS_SVH
`define PBX_CALL_STATE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PBX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pbx_pkg.sv
// ----------------------------------------------------------------------------
// pbx_pkg
// Types, codes and constants of the call state controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pbx_pkg;

  localparam int LINE_COUNT_DEF = 64;
  localparam int FIRST_LINE     = 4;

  typedef enum logic [2:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_PICKUP     = 3'd2,
    CMD_HANGUP     = 3'd3,
    CMD_DIAL       = 3'd4,
    CMD_CHAT       = 3'd5
  } cmd_t;

  // line states, also the low codes of the message kind
  localparam logic [2:0] ST_ON_HOOK   = 3'd0;
  localparam logic [2:0] ST_RINGING   = 3'd1;
  localparam logic [2:0] ST_DIAL_TONE = 3'd2;
  localparam logic [2:0] ST_RING_BACK = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_CONNECTED = 3'd5;
  localparam logic [2:0] ST_ERROR     = 3'd6;

  localparam logic [3:0] KIND_CHAT = 4'd7;
  localparam logic [3:0] KIND_NONE = 4'd8;

  // one line table entry; all zero is the reset value
  typedef struct packed {
    logic [2:0] state;
    logic       regd;
    logic [5:0] peer;
    logic       peer_vld;
  } entry_t;

  typedef struct packed {
    logic [5:0] dest;
    logic [3:0] kind;
    logic [5:0] shown;
  } res_t;

  // outcome of one command: table writes and notifications
  typedef struct packed {
    logic   wr_line;
    logic   wr_oth;
    entry_t line_ent;
    entry_t oth_ent;
    res_t   res0;
    res_t   res1;
    logic   two;
    logic   rej;
  } rule_out_t;

endpackage

`default_nettype wire

>>> hdl/pbx_call_state_controller.sv
// ----------------------------------------------------------------------------
// pbx_call_state_controller
// Telephone exchange call state controller. Each input item is one command
// (register, unregister, pickup, hangup, dial, chat) on one line; the block
// keeps per-line call state, a registered flag and a peer link in an on-chip
// table and answers each command with one or two notification items, the
// acting line first and then its peer or the dialed line, m_tlast marking
// the final one. Lines below 4 and at or above LINE_COUNT are never usable.
// Sequencing: one command at a time. A command passes through accept, peer
// lookup, rule evaluation with the acting-line write, peer write, then the
// notifications one after another, each held while m_tready is low; this
// order comes from the two dependent reads of the single-read-port table
// (acting line, then peer or target) and its single write port. The table
// comes out of reset ready to use: per-entry valid bits make unwritten
// lines read as on hook, unregistered, without peer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pbx_call_state_controller_macros.svh"

module pbx_call_state_controller #(
  parameter int LINE_COUNT = pbx_pkg::LINE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command item
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [2:0] cmd, [8:3] line, [14:9] dial_target
  // notification item
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [5:0] dest_line, [11:6] shown_number, [12] status
  output logic [3:0]       m_tuser,   // [3:0] msg_kind
  output logic             m_tlast
);
  import pbx_pkg::*;

  localparam int AW = $clog2(LINE_COUNT);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RD_OTH = 5'b00010,
    S_EXEC   = 5'b00100,
    S_WR2    = 5'b01000,
    S_OUT    = 5'b10000
  } fsm_t;

  fsm_t      state, state_next;
  logic      sel;
  logic [2:0] cmd_q;
  logic [5:0] line_q, tgt_q, oth_q;
  entry_t    le_q;
  entry_t    rd_data;
  rule_out_t ro, ro_q;
  res_t      res;
  logic [5:0] oth_num;
  logic [AW-1:0] rd_addr, wr_addr;
  logic      wr_en;
  entry_t    wr_data;
  logic      in_acc, out_acc;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  // other entry: dial target for dial, otherwise the stored peer
  assign oth_num = (cmd_q == CMD_DIAL) ? tgt_q : rd_data.peer;

  // read the acting line on accept, the other entry in the cycle after
  assign rd_addr = (state == S_IDLE) ? AW'(s_tdata[8:3]) : AW'(oth_num);

  // acting line is written during rule evaluation, the other entry after
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(line_q);
    wr_data = ro.line_ent;
    if (state == S_EXEC) begin
      wr_en = ro.wr_line;
    end else if (state == S_WR2) begin
      wr_en   = ro_q.wr_oth;
      wr_addr = AW'(oth_q);
      wr_data = ro_q.oth_ent;
    end
  end

  pbx_line_table #(
    .LINE_COUNT (LINE_COUNT),
    .AW         (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pbx_call_rules #(
    .LINE_COUNT (LINE_COUNT)
  ) u_rules (
    .cmd     (cmd_q),
    .line    (line_q),
    .tgt     (tgt_q),
    .oth_num (oth_q),
    .le      (le_q),
    .oe      (rd_data),
    .ro      (ro)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_acc) state_next = S_RD_OTH;
      S_RD_OTH: state_next = S_EXEC;
      S_EXEC:   state_next = S_WR2;
      S_WR2:    state_next = S_OUT;
      S_OUT:    if (out_acc && m_tlast) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      // advance to the second notification, drop back after the last
      if (out_acc) begin
        sel <= !m_tlast;
      end
    end
  end

  // payload holding registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q  <= s_tdata[2:0];
      line_q <= s_tdata[8:3];
      tgt_q  <= s_tdata[14:9];
    end
    if (state == S_RD_OTH) begin
      le_q  <= rd_data;
      oth_q <= oth_num;
    end
    if (state == S_EXEC) begin
      ro_q <= ro;
    end
  end

  assign res     = sel ? ro_q.res1 : ro_q.res0;
  assign m_tdata = {3'b000, ro_q.rej, res.shown, res.dest};
  assign m_tuser = res.kind;
  assign m_tlast = sel || !ro_q.two;

  `PBX_ASSERT_IMPL(a_idle_no_out, clk, rst, s_tready, !m_tvalid, "output while idle")
  `PBX_ASSERT_NEXT(a_accept_lookup, clk, rst, in_acc, state == S_RD_OTH, "no lookup after accept")
  `PBX_ASSERT_NEXT(a_last_frees, clk, rst, out_acc && m_tlast, s_tready, "not idle after last item")
  `PBX_ASSERT_IMPL(a_second_paired, clk, rst, m_tvalid && sel, ro_q.two, "second item without pair")

endmodule

`default_nettype wire

>>> hdl/pbx_line_table.sv
// ----------------------------------------------------------------------------
// pbx_line_table
// Per-line state memory, one read and one write port, registered read,
// with a valid bit per entry so unwritten entries read as reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module pbx_line_table #(
  parameter int LINE_COUNT = pbx_pkg::LINE_COUNT_DEF,
  parameter int AW         = $clog2(LINE_COUNT)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [AW-1:0]  rd_addr,
  output pbx_pkg::entry_t     rd_data,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire pbx_pkg::entry_t wr_data
);
  import pbx_pkg::*;

  entry_t                mem [LINE_COUNT];
  logic [LINE_COUNT-1:0] vld;
  entry_t                rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld_q <= (32'(rd_addr) < LINE_COUNT) && vld[rd_addr];
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

>>> hdl/pbx_call_rules.sv
// ----------------------------------------------------------------------------
// pbx_call_rules
// Transition rules: from the acting line's entry and the other entry (peer or
// dial target) work out the new entries and the notifications.
// ----------------------------------------------------------------------------
`default_nettype none

module pbx_call_rules #(
  parameter int LINE_COUNT = pbx_pkg::LINE_COUNT_DEF
) (
  input  wire logic [2:0]    cmd,
  input  wire logic [5:0]    line,
  input  wire logic [5:0]    tgt,
  input  wire logic [5:0]    oth_num,
  input  wire pbx_pkg::entry_t le,
  input  wire pbx_pkg::entry_t oe,
  output pbx_pkg::rule_out_t ro
);
  import pbx_pkg::*;

  function automatic logic in_range(logic [5:0] n);
    return (32'(n) >= FIRST_LINE) && (32'(n) < LINE_COUNT);
  endfunction

  function automatic res_t report(entry_t e, logic [5:0] num);
    res_t r;
    r.dest  = num;
    r.kind  = {1'b0, e.state};
    r.shown = 6'd0;
    if (e.state == ST_ON_HOOK) begin
      r.shown = num;
    end else if (e.state == ST_CONNECTED && e.peer_vld) begin
      r.shown = e.peer;
    end
    return r;
  endfunction

  logic   l_range, l_usable, o_usable, has, same;
  entry_t ln, ob, lr, of;

  assign l_range  = in_range(line);
  assign l_usable = l_range && le.regd;
  assign o_usable = in_range(oth_num) && oe.regd;
  assign has      = le.peer_vld && o_usable;
  assign same     = (oth_num == line);

  always_comb begin
    ro          = '0;
    ro.res0     = '{dest: line, kind: KIND_NONE, shown: 6'd0};
    ro.rej      = 1'b1;
    ln          = le;
    ob          = oe;
    lr          = le;
    of          = oe;
    if (cmd == CMD_REGISTER) begin
      if (l_range && !le.regd) begin
        ln          = '0;
        ln.regd     = 1'b1;
        ro.wr_line  = 1'b1;
        ro.line_ent = ln;
        ro.res0     = report(ln, line);
        ro.rej      = 1'b0;
      end
    end else if (l_usable) begin
      unique case (cmd)
        CMD_UNREGISTER: begin
          ln.regd     = 1'b0;
          ro.wr_line  = 1'b1;
          ro.line_ent = ln;
          ro.rej      = 1'b0;
        end
        CMD_PICKUP: begin
          ro.rej = 1'b0;
          if (le.state == ST_ON_HOOK) begin
            ln.state    = ST_DIAL_TONE;
            ro.wr_line  = 1'b1;
            ro.line_ent = ln;
            ro.res0     = report(ln, line);
          end else if (le.state == ST_RINGING && has) begin
            ln.state    = ST_CONNECTED;
            ob          = same ? ln : oe;
            ob.state    = ST_CONNECTED;
            ro.wr_line  = 1'b1;
            ro.wr_oth   = 1'b1;
            ro.line_ent = ln;
            ro.oth_ent  = ob;
            ro.res0     = report(ln, line);
            ro.res1     = report(ob, oth_num);
            ro.two      = 1'b1;
          end else begin
            ro.res0 = report(le, line);
          end
        end
        CMD_HANGUP: begin
          ro.rej   = 1'b0;
          ln.state = ST_ON_HOOK;
          ob       = same ? ln : oe;
          if (has) begin
            if (le.state == ST_CONNECTED || le.state == ST_RINGING) begin
              ob.state = ST_DIAL_TONE;
            end else if (le.state == ST_RING_BACK) begin
              ob.state = ST_ON_HOOK;
            end
          end
          // the acting line reports before the links are cleared
          lr          = same ? ob : ln;
          ro.res0     = report(lr, line);
          of          = ob;
          if (has) begin
            lr.peer_vld = 1'b0;
            of.peer_vld = 1'b0;
            ro.wr_oth   = 1'b1;
            ro.oth_ent  = of;
            ro.res1     = report(of, oth_num);
            ro.two      = 1'b1;
          end
          ro.wr_line  = 1'b1;
          ro.line_ent = lr;
        end
        CMD_DIAL: begin
          ro.rej = 1'b0;
          if (le.state == ST_DIAL_TONE) begin
            ro.wr_line = 1'b1;
            if (!o_usable) begin
              ln.state    = ST_ERROR;
              ln.peer_vld = 1'b0;
            end else if (oe.state == ST_ON_HOOK) begin
              ln.state    = ST_RING_BACK;
              ln.peer     = tgt;
              ln.peer_vld = 1'b1;
              ob.state    = ST_RINGING;
              ob.peer     = line;
              ob.peer_vld = 1'b1;
              ro.wr_oth   = 1'b1;
              ro.oth_ent  = ob;
              ro.res1     = report(ob, tgt);
              ro.two      = 1'b1;
            end else begin
              ln.state = ST_BUSY;
            end
            ro.line_ent = ln;
          end
          ro.res0 = report(ln, line);
        end
        CMD_CHAT: begin
          ro.res0 = report(le, line);
          if (le.state == ST_CONNECTED && has) begin
            ro.res1 = '{dest: le.peer, kind: KIND_CHAT, shown: 6'd0};
            ro.two  = 1'b1;
            ro.rej  = 1'b0;
          end
        end
        default: begin
          ro.rej = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_pbx_call_state_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pbx_call_state_controller
// Self-checking bench for the call state controller. A queue of commands
// feeds a clocked stream driver. Each accepted command runs through a local
// line table model that queues the notifications it should cause. A clocked
// monitor pops and compares them field by field. The stimulus starts with a
// short directed call walk-through and then runs random call scenarios and
// noise in several phases of sender idling and receiver stalls. One phase
// holds the receiver off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_pbx_call_state_controller;
  import pbx_pkg::*;

  localparam int LINES = LINE_COUNT_DEF;

  // command codes outside cmd_t, rejected by the block
  localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [5:0] dest;
    logic [3:0] kind;
    logic [5:0] shown;
    logic       status;
    logic       last;
  } notif_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [2:0] cmd, [8:3] line, [14:9] dial_target
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [5:0] dest_line, [11:6] shown_number, [12] status
  logic [3:0]  m_tuser;        // [3:0] msg_kind
  logic        m_tlast;

  pbx_call_state_controller #(.LINE_COUNT(LINES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // local copy of the line table
  logic [2:0] line_st      [LINES];
  bit         line_regd    [LINES];
  logic [5:0] line_peer    [LINES];
  bit         line_peer_vld[LINES];

  logic [15:0] cmd_backlog[$];
  notif_t      notif_expected[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_rejected = 0;
  int n_connected = 0;
  int n_chat = 0;
  int err_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cnt = 0;
  int hold_target = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line table model
  // --------------------------------------------------------------------------
  function automatic bit line_usable(int l);
    return l >= FIRST_LINE && l < LINES && line_regd[l];
  endfunction

  // status of line l as it is reported: own number on hook, peer when connected
  function automatic notif_t line_status(int l);
    notif_t r;
    r = '0;
    r.dest = l[5:0];
    r.kind = {1'b0, line_st[l]};
    if (line_st[l] == ST_ON_HOOK) r.shown = l[5:0];
    else if (line_st[l] == ST_CONNECTED && line_peer_vld[l]) r.shown = line_peer[l];
    return r;
  endfunction

  task automatic apply_call_command(input logic [15:0] item);
    notif_t     res[2];
    logic [2:0] cmd;
    logic [2:0] st;
    int         l;
    int         t;
    int         p;
    int         n;
    bit         rej;
    bit         has_peer;
    cmd = item[2:0];
    l = item[8:3];
    t = item[14:9];
    n = 1;
    rej = 1'b0;
    res[0] = '0;
    res[1] = '0;
    p = line_peer[l];
    has_peer = line_peer_vld[l] && line_usable(p);
    if (cmd == CMD_REGISTER) begin
      if (l < FIRST_LINE || l >= LINES || line_regd[l]) begin
        res[0] = '{dest: l[5:0], kind: KIND_NONE, shown: 6'd0, status: 1'b0, last: 1'b0};
        rej = 1'b1;
      end else begin
        line_regd[l] = 1'b1;
        line_st[l] = ST_ON_HOOK;
        line_peer_vld[l] = 1'b0;
        line_peer[l] = '0;
        res[0] = line_status(l);
      end
    end else if (cmd == CMD_UNDEF_LO || cmd == CMD_UNDEF_HI || !line_usable(l)) begin
      res[0] = '{dest: l[5:0], kind: KIND_NONE, shown: 6'd0, status: 1'b0, last: 1'b0};
      rej = 1'b1;
    end else if (cmd == CMD_UNREGISTER) begin
      // drop the registration only; state and peer link stay
      line_regd[l] = 1'b0;
      res[0] = '{dest: l[5:0], kind: KIND_NONE, shown: 6'd0, status: 1'b0, last: 1'b0};
    end else if (cmd == CMD_PICKUP) begin
      if (line_st[l] == ST_ON_HOOK) begin
        line_st[l] = ST_DIAL_TONE;
        res[0] = line_status(l);
      end else if (line_st[l] == ST_RINGING && has_peer) begin
        line_st[l] = ST_CONNECTED;
        line_st[p] = ST_CONNECTED;
        res[0] = line_status(l);
        res[1] = line_status(p);
        n = 2;
      end else begin
        res[0] = line_status(l);
      end
    end else if (cmd == CMD_HANGUP) begin
      st = line_st[l];
      if (st == ST_CONNECTED || st == ST_RINGING) begin
        line_st[l] = ST_ON_HOOK;
        if (has_peer) line_st[p] = ST_DIAL_TONE;
      end else if (st == ST_RING_BACK) begin
        line_st[l] = ST_ON_HOOK;
        if (has_peer) line_st[p] = ST_ON_HOOK;
      end else if (st == ST_DIAL_TONE || st == ST_BUSY || st == ST_ERROR) begin
        line_st[l] = ST_ON_HOOK;
      end
      res[0] = line_status(l);
      // break both links before the peer is reported
      if (has_peer) begin
        line_peer_vld[p] = 1'b0;
        line_peer_vld[l] = 1'b0;
        res[1] = line_status(p);
        n = 2;
      end
    end else if (cmd == CMD_DIAL) begin
      if (line_st[l] == ST_DIAL_TONE) begin
        if (!line_usable(t)) begin
          line_st[l] = ST_ERROR;
          line_peer_vld[l] = 1'b0;
        end else if (line_st[t] == ST_ON_HOOK) begin
          line_st[l] = ST_RING_BACK;
          line_peer[l] = t[5:0];
          line_peer_vld[l] = 1'b1;
          line_st[t] = ST_RINGING;
          line_peer[t] = l[5:0];
          line_peer_vld[t] = 1'b1;
          n = 2;
        end else begin
          line_st[l] = ST_BUSY;
        end
      end
      res[0] = line_status(l);
      if (n == 2) res[1] = line_status(t);
    end else begin
      // chat: own status first, then delivery to a connected peer
      res[0] = line_status(l);
      if (line_st[l] == ST_CONNECTED && has_peer) begin
        res[1] = '{dest: p[5:0], kind: KIND_CHAT, shown: 6'd0, status: 1'b0, last: 1'b0};
        n = 2;
      end else begin
        rej = 1'b1;
      end
    end
    for (int k = 0; k < n; k++) begin
      res[k].status = rej;
      res[k].last = (k == n - 1);
      notif_expected.push_back(res[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_call_command(s_tdata);
        n_accepted++;
      end
      // advance only when the current item is gone or none is offered
      if (!s_tvalid || s_tready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= cmd_backlog.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver hold-off counter, in cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) hold_cnt <= 0;
    else if (hold_cnt < hold_target) hold_cnt <= hold_cnt + 1;
  end

  // --------------------------------------------------------------------------
  // Notification monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    notif_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (m_tuser == {1'b0, ST_CONNECTED}) n_connected++;
        if (m_tuser == KIND_CHAT) n_chat++;
        if (m_tdata[12]) n_rejected++;
        if (notif_expected.size() == 0) begin
          $error("notification with none expected: dest %0d kind %0d",
                 m_tdata[5:0], m_tuser);
          err_count++;
        end else begin
          want = notif_expected.pop_front();
          if (m_tdata[5:0] !== want.dest) begin
            $error("dest_line: expected %0d, got %0d", want.dest, m_tdata[5:0]);
            err_count++;
          end
          if (m_tuser !== want.kind) begin
            $error("msg_kind: expected %0d, got %0d", want.kind, m_tuser);
            err_count++;
          end
          if (m_tdata[11:6] !== want.shown) begin
            $error("shown_number: expected %0d, got %0d", want.shown, m_tdata[11:6]);
            err_count++;
          end
          if (m_tdata[12] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[12]);
            err_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            err_count++;
          end
        end
      end
      m_tready <= (hold_cnt >= hold_target) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input logic [2:0] cmd, input int l, input int t);
    cmd_backlog.push_back({1'b0, t[5:0], l[5:0], cmd});
    n_queued++;
  endtask

  // lines in a small pool at both ends of the range, so calls collide often
  function automatic int pool_line();
    return $urandom_range(1) ? $urandom_range(4, 11) : $urandom_range(56, 63);
  endfunction

  function automatic int any_line();
    return ($urandom_range(4) == 0) ? $urandom_range(0, 63) : pool_line();
  endfunction

  task automatic add_noise_cmd();
    int         r;
    logic [2:0] cmd;
    r = $urandom_range(99);
    if (r < 12) cmd = CMD_REGISTER;
    else if (r < 18) cmd = CMD_UNREGISTER;
    else if (r < 40) cmd = CMD_PICKUP;
    else if (r < 58) cmd = CMD_HANGUP;
    else if (r < 82) cmd = CMD_DIAL;
    else if (r < 96) cmd = CMD_CHAT;
    else cmd = $urandom_range(1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
    queue_cmd(cmd, any_line(), $urandom_range(0, 63));
  endtask

  // one call from a to b with a random ending
  task automatic add_call_sequence();
    int a;
    int b;
    int talk;
    a = pool_line();
    b = pool_line();
    if ($urandom_range(3) != 0) queue_cmd(CMD_REGISTER, a, $urandom_range(0, 63));
    if ($urandom_range(3) != 0) queue_cmd(CMD_REGISTER, b, $urandom_range(0, 63));
    queue_cmd(CMD_PICKUP, a, $urandom_range(0, 63));
    queue_cmd(CMD_DIAL, a, ($urandom_range(9) == 0) ? $urandom_range(0, 63) : b);
    case ($urandom_range(5))
      0: queue_cmd(CMD_HANGUP, a, $urandom_range(0, 63));
      1: queue_cmd(CMD_HANGUP, b, $urandom_range(0, 63));
      2: begin
        // leave a stale link behind
        queue_cmd(CMD_UNREGISTER, $urandom_range(1) ? a : b, $urandom_range(0, 63));
        queue_cmd(CMD_CHAT, a, $urandom_range(0, 63));
        queue_cmd(CMD_HANGUP, a, $urandom_range(0, 63));
      end
      default: begin
        queue_cmd(CMD_PICKUP, b, $urandom_range(0, 63));
        talk = $urandom_range(3);
        for (int i = 0; i < talk; i++) begin
          queue_cmd(CMD_CHAT, $urandom_range(1) ? a : b, $urandom_range(0, 63));
        end
        if ($urandom_range(1)) begin
          queue_cmd(CMD_HANGUP, a, $urandom_range(0, 63));
          queue_cmd(CMD_HANGUP, b, $urandom_range(0, 63));
        end else begin
          queue_cmd(CMD_HANGUP, b, $urandom_range(0, 63));
          queue_cmd(CMD_HANGUP, a, $urandom_range(0, 63));
        end
      end
    endcase
  endtask

  task automatic add_random_phase(input int count);
    int stop;
    stop = n_queued + count;
    while (n_queued < stop) begin
      if ($urandom_range(99) < 65) add_call_sequence();
      else add_noise_cmd();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (n_accepted != n_queued || notif_expected.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < LINES; i++) begin
      line_st[i] = ST_ON_HOOK;
      line_regd[i] = 1'b0;
      line_peer[i] = '0;
      line_peer_vld[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed walk through the call rules
    queue_cmd(CMD_REGISTER, 0, 0);       // reserved line
    queue_cmd(CMD_REGISTER, 3, 63);      // reserved line
    queue_cmd(CMD_PICKUP, 5, 0);         // not registered
    queue_cmd(CMD_REGISTER, 4, 0);
    queue_cmd(CMD_REGISTER, 4, 0);       // already registered
    queue_cmd(CMD_REGISTER, 63, 0);
    queue_cmd(CMD_REGISTER, 5, 0);
    queue_cmd(CMD_UNDEF_LO, 4, 0);
    queue_cmd(CMD_UNDEF_HI, 63, 63);
    queue_cmd(CMD_CHAT, 4, 0);           // chat while on hook
    queue_cmd(CMD_DIAL, 4, 63);          // dial without dial tone
    queue_cmd(CMD_PICKUP, 4, 0);
    queue_cmd(CMD_PICKUP, 4, 0);         // re-report dial tone
    queue_cmd(CMD_DIAL, 4, 2);           // unusable target: error
    queue_cmd(CMD_HANGUP, 4, 0);
    queue_cmd(CMD_PICKUP, 4, 0);
    queue_cmd(CMD_DIAL, 4, 4);           // dial own line: busy
    queue_cmd(CMD_HANGUP, 4, 0);
    queue_cmd(CMD_PICKUP, 4, 0);
    queue_cmd(CMD_DIAL, 4, 63);          // ring back and ringing
    queue_cmd(CMD_PICKUP, 63, 0);        // connect both
    queue_cmd(CMD_CHAT, 4, 0);
    queue_cmd(CMD_HANGUP, 63, 0);        // peer drops to dial tone
    queue_cmd(CMD_PICKUP, 5, 0);
    queue_cmd(CMD_DIAL, 5, 4);           // target busy in dial tone
    queue_cmd(CMD_UNREGISTER, 63, 0);
    queue_cmd(CMD_CHAT, 63, 0);          // unregistered line
    wait_drained();

    // no idling
    add_random_phase(300);
    wait_drained();

    // hold the receiver off while the sender keeps offering
    hold_target = hold_cnt + 400;
    add_random_phase(40);
    wait_drained();

    // sender idles most cycles
    send_idle_pct = 71;
    add_random_phase(300);
    wait_drained();

    // receiver stalls most cycles
    send_idle_pct = 0;
    recv_stall_pct = 71;
    add_random_phase(300);
    wait_drained();

    // both sides idle now and then
    send_idle_pct = 20;
    recv_stall_pct = 20;
    add_random_phase(300);
    wait_drained();

    repeat (30) @(posedge clk);
    $display("Ran %0d commands through the line table, %0d notifications checked.",
             n_accepted, n_checked);
    $display("Saw %0d connected reports, %0d chat deliveries, %0d rejections.",
             n_connected, n_chat, n_rejected);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #6_000_000;
    $display("Timed out with %0d commands and %0d notifications outstanding.",
             n_queued - n_accepted, notif_expected.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
